// ===== src/fnv_pkg.sv =====
// Shared constants and types for the FNV-1a pseudonym generator.
package fnv_pkg;

   localparam int MaxPseudonymBytes = 32;
   localparam int LenCap = (MaxPseudonymBytes < 32) ? MaxPseudonymBytes : 32;

   localparam int LenW    = 6;
   localparam int PosW    = 5;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 64;

   localparam logic [31:0] FnvBasis = 32'h811c9dc5;
   localparam logic [31:0] FnvPrime = 32'h01000193;
   localparam logic [31:0] MixMult  = 32'h5bd1e995;
   localparam logic [LenW-1:0] LenReset = LenW'(16);

   localparam logic [CsrIdxW-1:0] RegSerialNumber    = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] RegPseudonymLength = CsrIdxW'(1);

   // Operands presented to the shared multiply-add unit.
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] addend;
   } mul_op_type;

   // Settings handed from the register file to the sequencer.
   typedef struct packed {
      logic [31:0]     serial_lo;
      logic [LenW-1:0] eff_len;
   } cfg_type;

endpackage

// ===== src/fnv_ifs.sv =====
// Handshake interfaces for the request, response and register write channels.
interface fnv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] id_byte;
   logic       byte_present;
   logic       final_item;

   modport source (output valid, id_byte, byte_present, final_item, input ready);
   modport sink   (input valid, id_byte, byte_present, final_item, output ready);
endinterface

interface fnv_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pseudonym_byte;
   logic [4:0] byte_position;
   logic       last_of_run;

   modport source (output valid, pseudonym_byte, byte_position, last_of_run, input ready);
   modport sink   (input valid, pseudonym_byte, byte_position, last_of_run, output ready);
endinterface

interface fnv_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/fnv_csr_regs.sv =====
// Configuration registers with length saturation.
module fnv_csr_regs (
   input  logic              clock,
   input  logic              reset,
   fnv_csr_if.sink           csr_port,
   output fnv_pkg::cfg_type  cfg
);
   import fnv_pkg::*;

   logic [CsrDataW-1:0] serial_ff;
   logic [LenW-1:0]     length_ff;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         serial_ff <= '0;
         length_ff <= LenReset;
      end else if (csr_port.valid) begin
         if (csr_port.index == RegSerialNumber) begin
            serial_ff <= csr_port.data;
         end else if (csr_port.index == RegPseudonymLength) begin
            length_ff <= csr_port.data[LenW-1:0];
         end
      end
   end

   assign cfg.serial_lo = serial_ff[31:0];
   assign cfg.eff_len   = (length_ff > LenW'(LenCap)) ? LenW'(LenCap) : length_ff;

endmodule

// ===== src/fnv_mul_unit.sv =====
// Shared 32-bit multiply-add unit, low word of a*b+addend, registered.
module fnv_mul_unit (
   input  logic                clock,
   input  fnv_pkg::mul_op_type op,
   output logic [31:0]         result
);
   import fnv_pkg::*;

   logic [31:0] result_ff;
   logic [31:0] result_in;

   assign result_in = (op.a * op.b) + op.addend;

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== src/fnv_pseudonym_generator.sv =====
// Top level: FNV-1a pseudonym generator with a sequencer around one multiplier.
//
//   Channel | Direction | Payload                                       | Accepted when
//   req     | in        | id_byte, byte_present, final_item             | valid && ready
//   rsp     | out       | pseudonym_byte, byte_position, last_of_run    | valid && ready
//   csr     | in        | index (0 serial_number, 1 pseudonym_length), data | valid && ready
//
// All multiplies share one registered 32x32 multiply-add unit. An item with a byte
// is hashed in HashWait, an empty non-final item is taken in Idle, and a final item
// adds a serial mix, then Emit and StepWait per pseudonym byte while rsp keeps up.
// A stalled response holds the sequencer in its emit step. The request side is ready
// only while idle; the last byte may still wait in the response register meanwhile.
// Reset is synchronous, active high, and restores the offset basis and register defaults.
module fnv_pseudonym_generator (
   input  logic      clock,
   input  logic      reset,
   fnv_req_if.sink   req_port,
   fnv_rsp_if.source rsp_port,
   fnv_csr_if.sink   csr_port
);
   import fnv_pkg::*;

   typedef enum logic [2:0] {
      Idle,
      HashWait,
      SerialIssue,
      SerialWait,
      Emit,
      StepWait
   } state_type;

   cfg_type     cfg;
   mul_op_type  mul_op;
   logic [31:0] mul_result;

   state_type       state_ff, state_in;
   logic [31:0]     hash_ff, hash_in;
   logic            final_ff, final_in;
   logic [LenW-1:0] idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic [PosW-1:0] rsp_pos_ff, rsp_pos_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            req_take;
   logic            slot_free;
   logic            is_last;
   logic [7:0]      hash_byte;

   fnv_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_port (csr_port),
      .cfg      (cfg)
   );

   fnv_mul_unit u_mul (
      .clock  (clock),
      .op     (mul_op),
      .result (mul_result)
   );

   assign req_port.ready = (state_ff == Idle);
   assign req_take       = req_port.valid && (state_ff == Idle);
   assign slot_free      = !rsp_valid_ff || rsp_port.ready;
   assign is_last        = ((idx_ff + LenW'(1)) == cfg.eff_len);

   // The byte of the hash picked by the low two bits of the position.
   always_comb begin
      unique case (idx_ff[1:0])
         2'd0:    hash_byte = hash_ff[7:0];
         2'd1:    hash_byte = hash_ff[15:8];
         2'd2:    hash_byte = hash_ff[23:16];
         default: hash_byte = hash_ff[31:24];
      endcase
   end

   // Operand selection for the shared multiplier; only the state that reads the
   // result back cares about what was issued.
   always_comb begin
      unique case (state_ff)
         Idle: begin
            mul_op.a      = hash_ff ^ {24'd0, req_port.id_byte};
            mul_op.b      = FnvPrime;
            mul_op.addend = '0;
         end
         SerialIssue: begin
            mul_op.a      = cfg.serial_lo;
            mul_op.b      = MixMult;
            mul_op.addend = '0;
         end
         default: begin
            mul_op.a      = hash_ff;
            mul_op.b      = MixMult;
            mul_op.addend = {{(32-LenW){1'b0}}, idx_ff};
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      final_in     = final_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         Idle: begin
            if (req_take) begin
               final_in = req_port.final_item;
               if (req_port.byte_present) begin
                  state_in = HashWait;
               end else if (req_port.final_item) begin
                  state_in = SerialIssue;
               end
            end
         end
         HashWait: begin
            hash_in  = mul_result;
            state_in = final_ff ? SerialIssue : Idle;
         end
         SerialIssue: begin
            state_in = SerialWait;
         end
         SerialWait: begin
            hash_in = hash_ff ^ mul_result;
            idx_in  = '0;
            if (cfg.eff_len == '0) begin
               // Nothing to emit, but the identifier is still closed.
               hash_in  = FnvBasis;
               state_in = Idle;
            end else begin
               state_in = Emit;
            end
         end
         Emit: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = hash_byte;
               rsp_pos_in   = idx_ff[PosW-1:0];
               rsp_last_in  = is_last;
               state_in     = StepWait;
            end
         end
         StepWait: begin
            idx_in = idx_ff + LenW'(1);
            if (is_last) begin
               hash_in  = FnvBasis;
               state_in = Idle;
            end else begin
               hash_in  = mul_result;
               state_in = Emit;
            end
         end
         default: begin
            state_in = Idle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= Idle;
         hash_ff      <= FnvBasis;
         final_ff     <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         final_ff     <= final_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.pseudonym_byte = rsp_byte_ff;
   assign rsp_port.byte_position  = rsp_pos_ff;
   assign rsp_port.last_of_run    = rsp_last_ff;

endmodule
